FILE: src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    typedef enum logic [2:0] {
        PH_SYNC    = 3'd0,
        PH_DISCARD = 3'd1,
        PH_DEST    = 3'd2,
        PH_SRC     = 3'd3,
        PH_TYPE    = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_LEN_LO  = 3'd6,
        PH_BODY    = 3'd7
    } phase_t;

    typedef logic [2:0] cfg_addr_t;

    localparam cfg_addr_t CFG_LINK_MODE     = 3'd0;
    localparam cfg_addr_t CFG_CABLE_SYNC    = 3'd1;
    localparam cfg_addr_t CFG_INFRARED_SYNC = 3'd2;
    localparam cfg_addr_t CFG_HOST_ADDR     = 3'd3;
    localparam cfg_addr_t CFG_HANDSET_ADDR  = 3'd4;

    localparam logic [7:0] ACK_TYPE = 8'h7f;

    localparam logic [7:0] CABLE_SYNC_RST    = 8'd31;
    localparam logic [7:0] INFRARED_SYNC_RST = 8'd20;
    localparam logic [7:0] HOST_ADDR_RST     = 8'd29;
    localparam logic [7:0] HANDSET_ADDR_RST  = 8'd0;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef logic [1:0] status_t;

    localparam status_t ST_HOST_MSG  = 2'd0;
    localparam status_t ST_HOST_ACK  = 2'd1;
    localparam status_t ST_HANDSET   = 2'd2;
    localparam status_t ST_BAD_CSUM  = 2'd3;

endpackage

FILE: src/serial_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_top
// Splits received link bytes into frames: streams payload bytes out and
// reports type, sequence, length and checksum/destination status on the closing byte.
//
//   channel   dir   handshake            payload
//   s_*       in    s_valid / s_ready    s_data_byte, s_gap_seen
//   m_*       out   m_valid / m_ready    m_kind .. m_status
//   cfg_*     in    cfg_we               cfg_addr, cfg_wdata
//
// One beat per cycle while s_ready is high; each beat is decoded in the
// cycle it is accepted; payload and closing results are registered.
// s_ready is low only while a result sits in the output register and
// m_ready is low. Synchronous active-low reset restores sync search and
// the default register values.
// ----------------------------------------------------------------------------
module serial_frame_deframer_top (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  sfd_pkg::cfg_addr_t   cfg_addr,
    input  logic [7:0]           cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_gap_seen,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [7:0]           m_payload_byte,
    output logic [7:0]           m_frame_type,
    output logic [7:0]           m_sequence_res,
    output logic [15:0]          m_frame_length,
    output sfd_pkg::status_t     m_status
);
    import sfd_pkg::*;

    logic        link_mode_reg;
    logic [7:0]  cable_sync_reg;
    logic [7:0]  infrared_sync_reg;
    logic [7:0]  host_addr_reg;
    logic [7:0]  handset_addr_reg;

    phase_t      phase_reg, phase_next;
    phase_t      eff_phase;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [16:0] count_reg, count_next;
    logic [7:0]  seq_reg, seq_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_kind_reg;
    logic [7:0]  m_payload_reg;
    logic [7:0]  m_type_reg;
    logic [7:0]  m_seq_reg;
    logic [15:0] m_len_reg;
    status_t     m_status_reg;

    logic        accept;
    logic        emit_payload;
    logic        emit_end;
    logic [7:0]  sync_byte;
    logic [16:0] len_ext;
    status_t     end_status;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign sync_byte = link_mode_reg ? infrared_sync_reg : cable_sync_reg;
    assign len_ext   = {1'b0, len_reg};
    assign eff_phase = (phase_reg == PH_DISCARD && s_gap_seen) ? PH_SYNC : phase_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_mode_reg     <= 1'b0;
            cable_sync_reg    <= CABLE_SYNC_RST;
            infrared_sync_reg <= INFRARED_SYNC_RST;
            host_addr_reg     <= HOST_ADDR_RST;
            handset_addr_reg  <= HANDSET_ADDR_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_LINK_MODE:     link_mode_reg     <= cfg_wdata[0];
                CFG_CABLE_SYNC:    cable_sync_reg    <= cfg_wdata;
                CFG_INFRARED_SYNC: infrared_sync_reg <= cfg_wdata;
                CFG_HOST_ADDR:     host_addr_reg     <= cfg_wdata;
                CFG_HANDSET_ADDR:  handset_addr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (eff_phase)
                PH_SYNC:    phase_next = (s_data_byte == sync_byte) ? PH_DEST : PH_DISCARD;
                PH_DISCARD: phase_next = PH_DISCARD;
                PH_DEST: begin
                    if (s_data_byte == host_addr_reg || s_data_byte == handset_addr_reg) begin
                        phase_next = PH_SRC;
                    end else begin
                        phase_next = PH_SYNC;
                    end
                end
                PH_SRC: begin
                    phase_next = PH_TYPE;
                    if (dest_reg == host_addr_reg) begin
                        if (s_data_byte != handset_addr_reg) phase_next = PH_SYNC;
                    end else if (dest_reg == handset_addr_reg) begin
                        if (s_data_byte != host_addr_reg) phase_next = PH_SYNC;
                    end
                end
                PH_TYPE:   phase_next = (s_data_byte == ACK_TYPE) ? PH_BODY : PH_LEN_HI;
                PH_LEN_HI: phase_next = PH_LEN_LO;
                PH_LEN_LO: phase_next = PH_BODY;
                PH_BODY:   phase_next = (count_reg > len_ext) ? PH_SYNC : PH_BODY;
                default:   phase_next = PH_SYNC;
            endcase
        end
    end

    // frame fields and results
    always_comb begin
        xor_next     = xor_reg;
        dest_next    = dest_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        seq_next     = seq_reg;
        emit_payload = 1'b0;
        emit_end     = 1'b0;
        if (accept) begin
            xor_next = xor_reg ^ s_data_byte;
            case (eff_phase)
                PH_SYNC: begin
                    if (s_data_byte == sync_byte) xor_next = sync_byte;
                end
                PH_DEST: dest_next = s_data_byte;
                PH_TYPE: begin
                    type_next = s_data_byte;
                    if (s_data_byte == ACK_TYPE) begin
                        len_next   = 16'd0;
                        count_next = 17'd0;
                    end
                end
                PH_LEN_HI: len_next = {s_data_byte, 8'd0};
                PH_LEN_LO: begin
                    len_next   = len_reg + {8'd0, s_data_byte};
                    count_next = 17'd0;
                end
                PH_BODY: begin
                    count_next = count_reg + 17'd1;
                    if (count_reg < len_ext) begin
                        emit_payload = 1'b1;
                    end else if (count_reg == len_ext) begin
                        seq_next = s_data_byte;
                    end else begin
                        emit_end = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (xor_next != 8'd0) begin
            end_status = ST_BAD_CSUM;
        end else if (dest_reg != host_addr_reg) begin
            end_status = ST_HANDSET;
        end else if (type_reg == ACK_TYPE) begin
            end_status = ST_HOST_ACK;
        end else begin
            end_status = ST_HOST_MSG;
        end
    end

    assign m_valid_next = (emit_payload || emit_end) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC;
            xor_reg     <= 8'd0;
            dest_reg    <= 8'd0;
            type_reg    <= 8'd0;
            len_reg     <= 16'd0;
            count_reg   <= 17'd0;
            seq_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            dest_reg    <= dest_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_payload || emit_end) begin
            m_kind_reg    <= emit_end ? KIND_END : KIND_PAYLOAD;
            m_payload_reg <= emit_end ? 8'd0 : s_data_byte;
            m_type_reg    <= type_reg;
            m_seq_reg     <= emit_end ? seq_reg : 8'd0;
            m_len_reg     <= len_reg;
            m_status_reg  <= emit_end ? end_status : ST_HOST_MSG;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_payload_byte = m_payload_reg;
    assign m_frame_type   = m_type_reg;
    assign m_sequence_res = m_seq_reg;
    assign m_frame_length = m_len_reg;
    assign m_status       = m_status_reg;

endmodule
